// ===== design/bpa_pkg.sv =====
package bpa_pkg;

   // Default sizing, handed down to the top level's parameters.
   localparam int PAGE_COUNT_DEF   = 4096;
   localparam int ORDER_LEVELS_DEF = 11;

   // Field widths fixed by the interface.
   localparam int PAGE_FIELD_W = 12;
   localparam int ORDER_W      = 4;
   localparam int ORD_CNT_W    = ORDER_W + 1;
   localparam int FREE_W       = 13;
   localparam int STATUS_W     = 2;
   localparam int CSR_DATA_W   = 13;
   localparam int CSR_INDEX_W  = 1;

   // Request kinds.
   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STAT_OK          = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_NO_BLOCK    = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_BAD_ORDER   = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_DOUBLE_FREE = 2'd3;

   // Configuration register indexes and reset values.
   localparam logic [CSR_INDEX_W-1:0] CSR_ZONE_BASE  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ZONE_TOTAL = 1'b1;
   localparam logic [PAGE_FIELD_W-1:0] ZONE_BASE_RESET  = 12'd0;
   localparam logic [CSR_DATA_W-1:0]   ZONE_TOTAL_RESET = 13'd4096;

   typedef struct packed {
      logic                    req_type;
      logic [ORDER_W-1:0]      block_order;
      logic [PAGE_FIELD_W-1:0] page_number;
   } req_item_type;

   typedef struct packed {
      logic [PAGE_FIELD_W-1:0] granted_page;
      logic [STATUS_W-1:0]     status;
      logic [FREE_W-1:0]       free_pages_left;
   } rsp_item_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DECODE,
      S_A_SEARCH,
      S_A_TAKE,
      S_A_SPLIT,
      S_F_CHK,
      S_F_LOOP,
      S_F_BUDCHK,
      S_W_CHK,
      S_W_ADV,
      S_CLRBUD,
      S_PUSH,
      S_FINISH
   } fsm_state_type;

   typedef enum logic [4:0] {
      OP_NOP,
      OP_CLEAR,
      OP_LOAD,
      OP_SEARCH_NEXT,
      OP_A_READ,
      OP_A_TAKE,
      OP_A_SPLIT,
      OP_A_DONE,
      OP_F_READ_PAGE,
      OP_F_READ_BUD,
      OP_W_INIT,
      OP_W_STEP,
      OP_W_ADV,
      OP_UNLINK,
      OP_CLEAR_BUD,
      OP_PUSH,
      OP_RESULT
   } dp_op_type;

   typedef struct packed {
      dp_op_type           op;
      logic [STATUS_W-1:0] status;
      logic                grant;
   } dp_cmd_type;

   typedef struct packed {
      logic clr_done;
      logic is_free;
      logic order_bad;
      logic page_bad;
      logic o_end;
      logic head_nil;
      logic o_above_tgt;
      logic o_top;
      logic bud_out;
      logic rd_mark;
      logic rd_ord_match;
      logic cur_nil;
      logic cur_is_bud;
      logic steps_max;
   } dp_stat_type;

endpackage

// ===== design/bpa_datapath.sv =====
module bpa_datapath #(
   parameter int PAGE_COUNT   = bpa_pkg::PAGE_COUNT_DEF,
   parameter int ORDER_LEVELS = bpa_pkg::ORDER_LEVELS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [bpa_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [bpa_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  bpa_pkg::req_item_type                 req_payload,
   input  bpa_pkg::dp_cmd_type                   cmd,
   output bpa_pkg::dp_stat_type                  dp_stat,
   output bpa_pkg::rsp_item_type                 rsp_payload
);

   localparam int PW  = $clog2(PAGE_COUNT);
   localparam int LW  = PW + 1;
   localparam int CW  = PW + 1;
   localparam int OIW = $clog2(ORDER_LEVELS);
   localparam int OW  = bpa_pkg::ORDER_W;
   localparam int MW  = 1 + OW + LW;
   localparam int FW  = bpa_pkg::FREE_W;
   localparam logic [LW-1:0] NIL = LW'(PAGE_COUNT);

   // Per-page word: free mark, block order, next link.
   logic [MW-1:0] page_mem [PAGE_COUNT];
   logic [MW-1:0] rd_ff;
   logic          mem_we, mem_re;
   logic [PW-1:0] mem_waddr, mem_raddr;
   logic [MW-1:0] mem_wdata;

   logic [bpa_pkg::PAGE_FIELD_W-1:0] zone_base_ff, zone_base_in;
   logic [bpa_pkg::CSR_DATA_W-1:0]   zone_total_ff, zone_total_in;
   logic [LW-1:0] head_ff [ORDER_LEVELS];
   logic [LW-1:0] head_in [ORDER_LEVELS];
   logic [FW-1:0] free_total_ff, free_total_in;
   logic [CW-1:0] clr_ff, clr_in;
   logic          is_free_ff, is_free_in;
   logic          page_bad_ff, page_bad_in;
   logic [bpa_pkg::ORD_CNT_W-1:0] tgt_ff, tgt_in, o_ff, o_in, o_dec;
   logic [PW-1:0] pfn_ff, pfn_in, bud_ff, bud_in;
   logic [LW-1:0] bud_link_ff, bud_link_in, cur_ff, cur_in, prev_ff, prev_in;
   logic [MW-1:0] prev_word_ff, prev_word_in;
   logic [CW-1:0] steps_ff, steps_in;
   bpa_pkg::rsp_item_type rsp_ff, rsp_in;

   logic [LW-1:0] head_sel, head_dec;
   logic [31:0]   pow_o, pow_dec, pow_tgt, bud32, half32, zone_end;
   logic          rd_mark;
   logic [OW-1:0] rd_ord;
   logic [LW-1:0] rd_link;

   always_comb begin
      o_dec    = o_ff - 1'b1;
      head_sel = (32'(o_ff) < ORDER_LEVELS) ? head_ff[o_ff[OIW-1:0]] : NIL;
      head_dec = head_ff[o_dec[OIW-1:0]];
      pow_o    = 32'd1 << o_ff;
      pow_dec  = 32'd1 << o_dec;
      pow_tgt  = 32'd1 << tgt_ff;
      bud32    = 32'(pfn_ff) ^ pow_o;
      half32   = 32'(pfn_ff) + pow_dec;
      zone_end = 32'(zone_base_ff) + 32'(zone_total_ff);
      rd_mark  = rd_ff[MW-1];
      rd_ord   = rd_ff[MW-2 -: OW];
      rd_link  = rd_ff[LW-1:0];
   end

   always_comb begin
      dp_stat.clr_done     = (clr_ff == CW'(PAGE_COUNT));
      dp_stat.is_free      = is_free_ff;
      dp_stat.order_bad    = (32'(tgt_ff) >= ORDER_LEVELS);
      dp_stat.page_bad     = page_bad_ff;
      dp_stat.o_end        = (32'(o_ff) >= ORDER_LEVELS);
      dp_stat.head_nil     = (head_sel == NIL);
      dp_stat.o_above_tgt  = (o_ff > tgt_ff);
      dp_stat.o_top        = (32'(o_ff) + 32'd1 >= ORDER_LEVELS);
      dp_stat.bud_out      = (bud32 < 32'(zone_base_ff)) || (bud32 >= zone_end)
                             || (bud32 >= PAGE_COUNT);
      dp_stat.rd_mark      = rd_mark;
      dp_stat.rd_ord_match = ({1'b0, rd_ord} == o_ff);
      dp_stat.cur_nil      = (cur_ff == NIL);
      dp_stat.cur_is_bud   = (cur_ff == LW'(bud_ff));
      dp_stat.steps_max    = (steps_ff == CW'(PAGE_COUNT));
   end

   always_comb begin
      zone_base_in  = zone_base_ff;
      zone_total_in = zone_total_ff;
      head_in       = head_ff;
      free_total_in = free_total_ff;
      clr_in        = clr_ff;
      is_free_in    = is_free_ff;
      page_bad_in   = page_bad_ff;
      tgt_in        = tgt_ff;
      o_in          = o_ff;
      pfn_in        = pfn_ff;
      bud_in        = bud_ff;
      bud_link_in   = bud_link_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      prev_word_in  = prev_word_ff;
      steps_in      = steps_ff;
      rsp_in        = rsp_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_waddr     = pfn_ff;
      mem_raddr     = pfn_ff;
      mem_wdata     = {1'b0, OW'(0), NIL};

      if (csr_we) begin
         unique case (csr_index)
            bpa_pkg::CSR_ZONE_BASE:  zone_base_in  = csr_wdata[bpa_pkg::PAGE_FIELD_W-1:0];
            bpa_pkg::CSR_ZONE_TOTAL: zone_total_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (cmd.op)
         bpa_pkg::OP_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff[PW-1:0];
            clr_in    = clr_ff + 1'b1;
         end
         bpa_pkg::OP_LOAD: begin
            is_free_in  = (req_payload.req_type == bpa_pkg::REQ_FREE);
            tgt_in      = bpa_pkg::ORD_CNT_W'(req_payload.block_order);
            o_in        = bpa_pkg::ORD_CNT_W'(req_payload.block_order);
            page_bad_in = (32'(req_payload.page_number) >= PAGE_COUNT);
            pfn_in      = PW'(req_payload.page_number);
         end
         bpa_pkg::OP_SEARCH_NEXT: o_in = o_ff + 1'b1;
         bpa_pkg::OP_A_READ: begin
            mem_re    = 1'b1;
            mem_raddr = head_sel[PW-1:0];
            pfn_in    = head_sel[PW-1:0];
         end
         bpa_pkg::OP_A_TAKE: begin
            head_in[o_ff[OIW-1:0]] = rd_link;
            mem_we = 1'b1;
         end
         bpa_pkg::OP_A_SPLIT: begin
            o_in = o_dec;
            if (half32 < PAGE_COUNT) begin
               mem_we    = 1'b1;
               mem_waddr = half32[PW-1:0];
               mem_wdata = {1'b1, o_dec[OW-1:0], head_dec};
               head_in[o_dec[OIW-1:0]] = LW'(half32[PW-1:0]);
            end else begin
               free_total_in = free_total_ff - FW'(pow_dec);
            end
         end
         bpa_pkg::OP_A_DONE: free_total_in = free_total_ff - FW'(pow_tgt);
         bpa_pkg::OP_F_READ_PAGE: mem_re = 1'b1;
         bpa_pkg::OP_F_READ_BUD: begin
            mem_re    = 1'b1;
            mem_raddr = bud32[PW-1:0];
            bud_in    = bud32[PW-1:0];
         end
         bpa_pkg::OP_W_INIT: begin
            bud_link_in = rd_link;
            cur_in      = head_sel;
            prev_in     = NIL;
            steps_in    = '0;
         end
         bpa_pkg::OP_W_STEP: begin
            mem_re    = 1'b1;
            mem_raddr = cur_ff[PW-1:0];
            prev_in   = cur_ff;
            steps_in  = steps_ff + 1'b1;
         end
         bpa_pkg::OP_W_ADV: begin
            cur_in       = rd_link;
            prev_word_in = rd_ff;
         end
         bpa_pkg::OP_UNLINK: begin
            if (prev_ff == NIL) begin
               head_in[o_ff[OIW-1:0]] = bud_link_ff;
            end else begin
               mem_we    = 1'b1;
               mem_waddr = prev_ff[PW-1:0];
               mem_wdata = {prev_word_ff[MW-1 -: 1+OW], bud_link_ff};
            end
         end
         bpa_pkg::OP_CLEAR_BUD: begin
            mem_we        = 1'b1;
            mem_waddr     = bud_ff;
            free_total_in = free_total_ff - FW'(pow_o);
            pfn_in        = (bud_ff < pfn_ff) ? bud_ff : pfn_ff;
            o_in          = o_ff + 1'b1;
         end
         bpa_pkg::OP_PUSH: begin
            mem_we    = 1'b1;
            mem_wdata = {1'b1, o_ff[OW-1:0], head_sel};
            head_in[o_ff[OIW-1:0]] = LW'(pfn_ff);
            free_total_in = free_total_ff + FW'(pow_o);
         end
         bpa_pkg::OP_RESULT: begin
            rsp_in.granted_page    = cmd.grant ? bpa_pkg::PAGE_FIELD_W'(pfn_ff) : '0;
            rsp_in.status          = cmd.status;
            rsp_in.free_pages_left = free_total_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         page_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_ff <= page_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zone_base_ff  <= bpa_pkg::ZONE_BASE_RESET;
         zone_total_ff <= bpa_pkg::ZONE_TOTAL_RESET;
         free_total_ff <= '0;
         clr_ff        <= '0;
         for (int i = 0; i < ORDER_LEVELS; i++) begin
            head_ff[i] <= NIL;
         end
      end else begin
         zone_base_ff  <= zone_base_in;
         zone_total_ff <= zone_total_in;
         free_total_ff <= free_total_in;
         clr_ff        <= clr_in;
         head_ff       <= head_in;
      end
   end

   always_ff @(posedge clock) begin
      is_free_ff   <= is_free_in;
      page_bad_ff  <= page_bad_in;
      tgt_ff       <= tgt_in;
      o_ff         <= o_in;
      pfn_ff       <= pfn_in;
      bud_ff       <= bud_in;
      bud_link_ff  <= bud_link_in;
      cur_ff       <= cur_in;
      prev_ff      <= prev_in;
      prev_word_ff <= prev_word_in;
      steps_ff     <= steps_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_payload = rsp_ff;

endmodule

// ===== design/bpa_ctrl.sv =====
module bpa_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  bpa_pkg::dp_stat_type dp_stat,
   output bpa_pkg::dp_cmd_type  cmd
);

   bpa_pkg::fsm_state_type state_ff, state_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [bpa_pkg::STATUS_W-1:0] res_stat_ff, res_stat_in;
   logic                   res_grant_ff, res_grant_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bpa_pkg::S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_stat_ff  <= res_stat_in;
      res_grant_ff <= res_grant_in;
   end

   always_comb begin
      state_in     = state_ff;
      res_stat_in  = res_stat_ff;
      res_grant_in = res_grant_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd          = '{op: bpa_pkg::OP_NOP, status: bpa_pkg::STAT_OK, grant: 1'b0};

      unique case (state_ff)
         bpa_pkg::S_CLEAR: begin
            if (dp_stat.clr_done) begin
               state_in = bpa_pkg::S_IDLE;
            end else begin
               cmd.op = bpa_pkg::OP_CLEAR;
            end
         end
         bpa_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = bpa_pkg::OP_LOAD;
               state_in = bpa_pkg::S_DECODE;
            end
         end
         bpa_pkg::S_DECODE: begin
            res_grant_in = 1'b0;
            res_stat_in  = bpa_pkg::STAT_OK;
            if (dp_stat.order_bad || (dp_stat.is_free && dp_stat.page_bad)) begin
               res_stat_in = bpa_pkg::STAT_BAD_ORDER;
               state_in    = bpa_pkg::S_FINISH;
            end else if (!dp_stat.is_free) begin
               state_in = bpa_pkg::S_A_SEARCH;
            end else begin
               cmd.op   = bpa_pkg::OP_F_READ_PAGE;
               state_in = bpa_pkg::S_F_CHK;
            end
         end
         bpa_pkg::S_A_SEARCH: begin
            if (dp_stat.o_end) begin
               res_stat_in = bpa_pkg::STAT_NO_BLOCK;
               state_in    = bpa_pkg::S_FINISH;
            end else if (dp_stat.head_nil) begin
               cmd.op = bpa_pkg::OP_SEARCH_NEXT;
            end else begin
               cmd.op   = bpa_pkg::OP_A_READ;
               state_in = bpa_pkg::S_A_TAKE;
            end
         end
         bpa_pkg::S_A_TAKE: begin
            cmd.op   = bpa_pkg::OP_A_TAKE;
            state_in = bpa_pkg::S_A_SPLIT;
         end
         bpa_pkg::S_A_SPLIT: begin
            if (dp_stat.o_above_tgt) begin
               cmd.op = bpa_pkg::OP_A_SPLIT;
            end else begin
               cmd.op       = bpa_pkg::OP_A_DONE;
               res_grant_in = 1'b1;
               state_in     = bpa_pkg::S_FINISH;
            end
         end
         bpa_pkg::S_F_CHK: begin
            if (dp_stat.rd_mark) begin
               res_stat_in = bpa_pkg::STAT_DOUBLE_FREE;
               state_in    = bpa_pkg::S_FINISH;
            end else begin
               state_in = bpa_pkg::S_F_LOOP;
            end
         end
         bpa_pkg::S_F_LOOP: begin
            if (dp_stat.o_top || dp_stat.bud_out) begin
               state_in = bpa_pkg::S_PUSH;
            end else begin
               cmd.op   = bpa_pkg::OP_F_READ_BUD;
               state_in = bpa_pkg::S_F_BUDCHK;
            end
         end
         bpa_pkg::S_F_BUDCHK: begin
            if (!dp_stat.rd_mark || !dp_stat.rd_ord_match) begin
               state_in = bpa_pkg::S_PUSH;
            end else begin
               cmd.op   = bpa_pkg::OP_W_INIT;
               state_in = bpa_pkg::S_W_CHK;
            end
         end
         bpa_pkg::S_W_CHK: begin
            if (dp_stat.cur_is_bud) begin
               cmd.op   = bpa_pkg::OP_UNLINK;
               state_in = bpa_pkg::S_CLRBUD;
            end else if (dp_stat.cur_nil || dp_stat.steps_max) begin
               state_in = bpa_pkg::S_PUSH;
            end else begin
               cmd.op   = bpa_pkg::OP_W_STEP;
               state_in = bpa_pkg::S_W_ADV;
            end
         end
         bpa_pkg::S_W_ADV: begin
            cmd.op   = bpa_pkg::OP_W_ADV;
            state_in = bpa_pkg::S_W_CHK;
         end
         bpa_pkg::S_CLRBUD: begin
            cmd.op   = bpa_pkg::OP_CLEAR_BUD;
            state_in = bpa_pkg::S_F_LOOP;
         end
         bpa_pkg::S_PUSH: begin
            cmd.op   = bpa_pkg::OP_PUSH;
            state_in = bpa_pkg::S_FINISH;
         end
         bpa_pkg::S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = bpa_pkg::OP_RESULT;
               cmd.status   = res_stat_ff;
               cmd.grant    = res_grant_ff;
               rsp_valid_in = 1'b1;
               state_in     = bpa_pkg::S_IDLE;
            end
         end
         default: state_in = bpa_pkg::S_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   // A sync reset always restarts the clearing pass.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> state_ff == bpa_pkg::S_CLEAR)
      else $error("reset did not restart the clearing pass");

   a_result_raises_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.op == bpa_pkg::OP_RESULT |=> rsp_valid_ff)
      else $error("result loaded without a valid beat");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.op == bpa_pkg::OP_RESULT |-> (!rsp_valid_ff || rsp_ready))
      else $error("pending result overwritten");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff == bpa_pkg::S_DECODE)
      else $error("accepted request not decoded");

endmodule

// ===== design/buddy_page_allocator.sv =====
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_ready  req_type, block_order, page_number
// rsp_      out        rsp_valid/rsp_ready  granted_page, status, free_pages_left
// csr_      in         csr_we (no wait)     csr_index, csr_wdata
//
// After reset a clearing pass sweeps the page memory, one entry a cycle; no request
// beat is taken until it ends (configuration writes are).
// An allocate searches the orders upward for a non-empty list, then splits the block down.
// A free checks the page, then per merge level reads the buddy and walks the list to it,
// the walk being set by the single read port of the page memory.
// One request is in work at a time; a finished result waits in the output register
// while the next request beat is accepted and processed.
module buddy_page_allocator #(
   parameter int PAGE_COUNT   = bpa_pkg::PAGE_COUNT_DEF,
   parameter int ORDER_LEVELS = bpa_pkg::ORDER_LEVELS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  bpa_pkg::req_item_type           req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output bpa_pkg::rsp_item_type           rsp_payload,
   input  logic                            csr_we,
   input  logic [bpa_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bpa_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   // Commands flow from the sequencer to the datapath; status flows back.
   bpa_pkg::dp_cmd_type  cmd;
   bpa_pkg::dp_stat_type dp_stat;

   // The controller walks alloc searches, splits, buddy checks and list walks.
   bpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .dp_stat   (dp_stat),
      .cmd       (cmd)
   );

   // The datapath holds the page memory, the list heads, the free total and the zone.
   bpa_datapath #(
      .PAGE_COUNT   (PAGE_COUNT),
      .ORDER_LEVELS (ORDER_LEVELS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_payload (req_payload),
      .cmd         (cmd),
      .dp_stat     (dp_stat),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== sim/buddy_page_allocator_tb.sv =====
`timescale 1ns / 1ps

module buddy_page_allocator_tb;

   localparam int PAGES     = bpa_pkg::PAGE_COUNT_DEF;
   localparam int LEVELS    = bpa_pkg::ORDER_LEVELS_DEF;
   localparam int NIL       = PAGES;
   localparam int CYCLE_CAP = 4_000_000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   bpa_pkg::req_item_type req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   bpa_pkg::rsp_item_type rsp_payload;
   logic                  csr_we = 1'b0;
   logic [bpa_pkg::CSR_INDEX_W-1:0] csr_index = bpa_pkg::CSR_ZONE_BASE;
   logic [bpa_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   buddy_page_allocator i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // The clock runs with a 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the allocator state. It is advanced once per accepted request beat,
   // at the edge of acceptance, so it always reflects the order in which the block works.
   bit               page_marked [PAGES];
   logic [3:0]       page_order  [PAGES];
   int               page_link   [PAGES];
   int               order_head  [LEVELS];
   logic [12:0]      order_len   [LEVELS];
   logic [12:0]      pages_free;
   int               zone_first;
   int               zone_size;

   bpa_pkg::rsp_item_type awaited_rsp[$];
   int               fail_count = 0;
   int               cycle_count = 0;
   bit               calm = 1'b0;
   int               hold_ask = 0;

   // Blocks handed out by the allocator and not yet given back, kept so that the random
   // traffic frees real blocks and the coalescing paths are actually exercised.
   int               held_page[$];
   int               held_order[$];

   task automatic shadow_reset();
      for (int i = 0; i < PAGES; i++) begin
         page_marked[i] = 1'b0;
         page_order[i]  = '0;
         page_link[i]   = NIL;
      end
      for (int i = 0; i < LEVELS; i++) begin
         order_head[i] = NIL;
         order_len[i]  = '0;
      end
      pages_free = '0;
      zone_first = bpa_pkg::ZONE_BASE_RESET;
      zone_size  = bpa_pkg::ZONE_TOTAL_RESET;
   endtask

   task automatic list_push(input int pg, input int o);
      page_marked[pg] = 1'b1;
      page_order[pg]  = o[3:0];
      page_link[pg]   = order_head[o];
      order_head[o]   = pg;
      order_len[o]    = order_len[o] + 13'd1;
   endtask

   // Give a block back and coalesce with its buddy for as long as the buddy is inside
   // the zone, free at the same order and actually found on its list.
   task automatic give_back(input int pfn, input int o);
      int bud;
      int prev;
      int cur;
      int steps;
      while (o + 1 < LEVELS) begin
         bud = pfn ^ (1 << o);
         if (bud < zone_first || bud >= zone_first + zone_size || bud >= PAGES) break;
         if (!page_marked[bud] || page_order[bud] != o[3:0]) break;
         prev  = NIL;
         cur   = order_head[o];
         steps = 0;
         while (cur != NIL && cur != bud && steps < PAGES) begin
            prev = cur;
            cur  = page_link[cur];
            steps++;
         end
         if (cur != bud) break;
         if (prev == NIL) order_head[o] = page_link[bud];
         else page_link[prev] = page_link[bud];
         order_len[o]     = order_len[o] - 13'd1;
         pages_free       = pages_free - 13'(1 << o);
         page_marked[bud] = 1'b0;
         page_order[bud]  = '0;
         page_link[bud]   = NIL;
         if (bud < pfn) pfn = bud;
         o++;
      end
      list_push(pfn, o);
      pages_free = pages_free + 13'(1 << o);
   endtask

   // Take the head of the smallest non-empty list at or above the order and split it
   // down; an upper half that would lie beyond the page space is simply lost.
   task automatic carve_block(input int want, output bit ok, output int pg);
      int half;
      ok = 1'b0;
      pg = 0;
      for (int o = want; o < LEVELS && !ok; o++) begin
         if (order_head[o] != NIL) begin
            pg            = order_head[o];
            order_head[o] = page_link[pg];
            order_len[o]  = order_len[o] - 13'd1;
            page_marked[pg] = 1'b0;
            page_link[pg]   = NIL;
            for (int s = o - 1; s >= want; s--) begin
               half = pg + (1 << s);
               if (half < PAGES) list_push(half, s);
               else pages_free = pages_free - 13'(1 << s);
            end
            page_order[pg] = '0;
            pages_free = pages_free - 13'(1 << want);
            ok = 1'b1;
         end
      end
   endtask

   // Works out the result of one request and updates the shadow state.
   task automatic buddy_predict(input bpa_pkg::req_item_type it,
                                output bpa_pkg::rsp_item_type r);
      bit ok;
      int pg;
      r = '0;
      if (it.block_order >= LEVELS) begin
         r.status = bpa_pkg::STAT_BAD_ORDER;
      end else if (it.req_type == bpa_pkg::REQ_ALLOC) begin
         carve_block(it.block_order, ok, pg);
         if (ok) begin
            r.granted_page = pg[11:0];
            held_page.push_back(pg);
            held_order.push_back(it.block_order);
         end else begin
            r.status = bpa_pkg::STAT_NO_BLOCK;
         end
      end else if (page_marked[it.page_number]) begin
         r.status = bpa_pkg::STAT_DOUBLE_FREE;
      end else begin
         give_back(it.page_number, it.block_order);
      end
      r.free_pages_left = pages_free;
   endtask

   // Sends one request beat. Valid is only lowered when a gap is taken, so back-to-back
   // beats never see valid dropped and raised within the same step.
   task automatic send_req(input logic kind, input int o, input int pg);
      bpa_pkg::req_item_type it;
      bpa_pkg::rsp_item_type r;
      it.req_type    = kind;
      it.block_order = o[3:0];
      it.page_number = pg[11:0];
      if (!calm && $urandom_range(99) < 24) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= it;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      buddy_predict(it, r);
      awaited_rsp.push_back(r);
   endtask

   task automatic stop_sending();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Waits until every expected result beat has arrived; the block is then idle.
   task automatic drain();
      stop_sending();
      while (awaited_rsp.size() != 0) @(posedge clock);
   endtask

   // Both zone registers are written on consecutive edges while the block is idle.
   task automatic set_zone(input int first, input int size);
      csr_we    <= 1'b1;
      csr_index <= bpa_pkg::CSR_ZONE_BASE;
      csr_wdata <= 13'(first);
      @(posedge clock);
      csr_index <= bpa_pkg::CSR_ZONE_TOTAL;
      csr_wdata <= 13'(size);
      @(posedge clock);
      csr_we    <= 1'b0;
      zone_first = first & 12'hFFF;
      zone_size  = size & 13'h1FFF;
      @(posedge clock);
   endtask

   // Result checker: every beat taken from the block is compared with the oldest
   // expectation, field by field.
   always @(posedge clock) begin
      bpa_pkg::rsp_item_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_rsp.size() == 0) begin
            $display("%0t: result beat with nothing expected: page %0d status %0d free %0d",
                     $time, rsp_payload.granted_page, rsp_payload.status,
                     rsp_payload.free_pages_left);
            fail_count++;
         end else begin
            want = awaited_rsp.pop_front();
            if (rsp_payload.granted_page !== want.granted_page) begin
               $display("%0t: granted_page expected %0d actual %0d", $time,
                        want.granted_page, rsp_payload.granted_page);
               fail_count++;
            end
            if (rsp_payload.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time,
                        want.status, rsp_payload.status);
               fail_count++;
            end
            if (rsp_payload.free_pages_left !== want.free_pages_left) begin
               $display("%0t: free_pages_left expected %0d actual %0d", $time,
                        want.free_pages_left, rsp_payload.free_pages_left);
               fail_count++;
            end
         end
      end
   end

   // Receiver: stalls at random, not at all when calm, and on request holds off for a
   // long stretch counted here so that the block backs up into its input.
   always @(posedge clock) begin
      int hold_left;
      if (hold_ask > 0) begin
         hold_left = hold_ask;
         hold_ask  = 0;
      end
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_ready <= calm ? 1'b1 : ($urandom_range(99) >= 24);
      end
   end

   // Watchdog on the whole run, which includes the clearing pass after reset.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_CAP) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Directed requests: empty lists, a split whose upper halves fall off the end of the
   // page space, merging up through several orders, double frees, bad orders and the
   // highest order.
   task automatic test_directed();
      send_req(bpa_pkg::REQ_ALLOC, 0, 0);
      send_req(bpa_pkg::REQ_FREE, 3, 4095);
      send_req(bpa_pkg::REQ_ALLOC, 0, 0);
      for (int p = 0; p < 8; p++) send_req(bpa_pkg::REQ_FREE, 0, p);
      send_req(bpa_pkg::REQ_FREE, 0, 0);
      send_req(bpa_pkg::REQ_ALLOC, 11, 0);
      send_req(bpa_pkg::REQ_ALLOC, 15, 4095);
      send_req(bpa_pkg::REQ_FREE, 12, 5);
      send_req(bpa_pkg::REQ_FREE, 15, 4095);
      send_req(bpa_pkg::REQ_ALLOC, 1, 0);
      send_req(bpa_pkg::REQ_FREE, 10, 2048);
      send_req(bpa_pkg::REQ_ALLOC, 10, 0);
      send_req(bpa_pkg::REQ_ALLOC, 10, 0);
      send_req(bpa_pkg::REQ_FREE, 1, 0);
      send_req(bpa_pkg::REQ_FREE, 0, 1);
      drain();
   endtask

   // Zone limits: buddies outside the zone are never merged, the freed page itself is.
   task automatic test_zone();
      set_zone(2048, 16);
      send_req(bpa_pkg::REQ_FREE, 0, 2048);
      send_req(bpa_pkg::REQ_FREE, 0, 2049);
      send_req(bpa_pkg::REQ_FREE, 0, 100);
      send_req(bpa_pkg::REQ_FREE, 0, 101);
      send_req(bpa_pkg::REQ_FREE, 4, 2064);
      send_req(bpa_pkg::REQ_FREE, 4, 2048 + 16 + 32);
      drain();
      set_zone(4095, 4096);
      send_req(bpa_pkg::REQ_FREE, 0, 4094);
      send_req(bpa_pkg::REQ_FREE, 0, 4095);
      drain();
      set_zone(0, 0);
      send_req(bpa_pkg::REQ_FREE, 0, 200);
      send_req(bpa_pkg::REQ_FREE, 0, 201);
      drain();
      set_zone(0, 4096);
   endtask

   // One random request. Most traffic is allocations and frees of blocks actually held,
   // with fresh pages released now and then and some plain noise.
   task automatic random_req();
      int pick;
      int k;
      int pg;
      int o;
      pick = $urandom_range(99);
      if (pick < 5) begin
         send_req(1'($urandom_range(1)), $urandom_range(15, LEVELS), $urandom_range(4095));
      end else if (pick < 45) begin
         o = ($urandom_range(9) == 0) ? $urandom_range(LEVELS - 1) : $urandom_range(3);
         send_req(bpa_pkg::REQ_ALLOC, o, $urandom_range(4095));
      end else if (pick < 80 && held_page.size() != 0) begin
         k  = $urandom_range(held_page.size() - 1);
         pg = held_page[k];
         o  = held_order[k];
         held_page.delete(k);
         held_order.delete(k);
         send_req(bpa_pkg::REQ_FREE, o, pg);
      end else if (pick < 93) begin
         send_req(bpa_pkg::REQ_FREE, 0, $urandom_range(4095));
      end else begin
         send_req(bpa_pkg::REQ_FREE, $urandom_range(LEVELS - 1), $urandom_range(4095));
      end
   endtask

   task automatic test_random(input int count);
      repeat (count) random_req();
      drain();
   endtask

   // The receiver holds off while requests keep coming, so the block must stall its input.
   task automatic test_backpressure();
      hold_ask = 400;
      repeat (12) random_req();
      drain();
   endtask

   initial begin
      shadow_reset();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_zone();
      test_random(150);
      calm = 1'b1;
      test_random(150);
      calm = 1'b0;
      test_backpressure();
      set_zone($urandom_range(4095), $urandom_range(4096));
      test_random(150);
      set_zone(0, 4096);
      test_random(150);

      repeat (50) @(posedge clock);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/bpa_pkg.sv
design/bpa_datapath.sv
design/bpa_ctrl.sv
design/buddy_page_allocator.sv
sim/buddy_page_allocator_tb.sv
